// ===== rtl/bloom_filter_engine_top_defines.svh =====
// ---------------------------------------------------------------------------
// bloom filter engine assertion macros
// clocked assertion wrappers, with and without a reset qualifier
// ---------------------------------------------------------------------------
`ifndef BLOOM_FILTER_ENGINE_TOP_DEFINES_SVH
`define BLOOM_FILTER_ENGINE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BFE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define BFE_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define BFE_ASSERT(lbl, clk, rst_n, prop)
`define BFE_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== rtl/bfe_pkg.sv =====
// ---------------------------------------------------------------------------
// bfe_pkg
// shared types and constants of the bloom filter engine
// ---------------------------------------------------------------------------
`default_nettype none
package bfe_pkg;
    localparam int MaxBits   = 16777216;
    localparam int MaxHashes = 8;
    localparam int AddrW     = $clog2(MaxBits);
    localparam int HIdxW     = $clog2(MaxHashes);
    localparam int ClrRowW   = 6;
    localparam int ClrRows   = MaxBits >> ClrRowW;
    localparam int ClrCntW   = AddrW - ClrRowW;
    localparam logic [1:0] CmdInsert = 2'd0;
    localparam logic [1:0] CmdLookup = 2'd1;
    localparam logic [1:0] CmdClear  = 2'd2;
    localparam logic [1:0] CmdIgnore = 2'd3;
    localparam logic [24:0] FilterBitsRst = 25'd10000000;
    localparam logic [3:0]  HashCountRst  = 4'd7;
    localparam logic [0:0] RegFilterBits = 1'b0;
    localparam logic [0:0] RegHashCount  = 1'b1;

    // job handed from front to back
    typedef struct packed {
        logic [1:0] cmd;
        logic [MaxHashes*64-1:0] hashes;
    } t_job;
endpackage
`default_nettype wire

// ===== rtl/bfe_front.sv =====
// ---------------------------------------------------------------------------
// bfe_front
// folds key bytes into the running hashes and emits one job per key or clear
// ---------------------------------------------------------------------------
`default_nettype none
module bfe_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    output logic              o_full,
    input  wire logic [1:0]   i_command,
    input  wire logic [7:0]   i_key_byte,
    input  wire logic         i_last_byte,
    output logic              o_job_vld,
    output bfe_pkg::t_job     o_job,
    input  wire logic         i_job_rdy
);
    logic [63:0] r_h [bfe_pkg::MaxHashes];
    logic [63:0] n_h [bfe_pkg::MaxHashes];
    logic [63:0] w_sext;
    logic        w_acc;
    logic        w_emit;
    logic        r_job_vld;
    bfe_pkg::t_job r_job;
    bfe_pkg::t_job n_job;

    // the job slot frees up at the edge the back end takes it
    assign o_full = r_job_vld && !i_job_rdy;
    assign w_acc  = i_push && !o_full;
    assign w_sext = {{56{i_key_byte[7]}}, i_key_byte};
    assign w_emit = (i_command == bfe_pkg::CmdClear) ||
                    ((i_command == bfe_pkg::CmdInsert || i_command == bfe_pkg::CmdLookup)
                     && i_last_byte);
    assign o_job_vld = r_job_vld;
    assign o_job     = r_job;

    always_comb begin
        n_job.cmd = i_command;
        for (int i = 0; i < bfe_pkg::MaxHashes; i++) begin
            n_h[i] = (r_h[i] << 7) + (r_h[i] << 1) + r_h[i] + w_sext;
            n_job.hashes[i*64 +: 64] = n_h[i];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < bfe_pkg::MaxHashes; i++) begin
            if (!i_rst_n) begin
                r_h[i] <= 64'(i + 1);
            end else if (w_acc && i_command != bfe_pkg::CmdIgnore) begin
                // end of key or clear reseeds
                r_h[i] <= w_emit ? 64'(i + 1) : n_h[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_vld <= 1'b0;
        end else if (w_acc && w_emit) begin
            r_job_vld <= 1'b1;
            r_job     <= n_job;
        end else if (r_job_vld && i_job_rdy) begin
            r_job_vld <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/bfe_mod.sv =====
// ---------------------------------------------------------------------------
// bfe_mod
// bit-serial 64-bit remainder by the filter size, one bit a cycle
// ---------------------------------------------------------------------------
`default_nettype none
module bfe_mod (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [24:0] i_den,
    output logic             o_done,
    output logic [24:0]      o_rem
);
    logic [63:0] r_num;
    logic [25:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [25:0] w_sh;
    logic [25:0] w_sub;

    assign w_sh  = {r_rem[24:0], r_num[63]};
    assign w_sub = w_sh - {1'b0, i_den};
    assign o_rem = r_rem[24:0];
    assign o_done = r_busy && r_cnt == 7'd64;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_num  <= i_num;
            r_rem  <= '0;
        end else if (r_busy && r_cnt != 7'd64) begin
            r_cnt <= r_cnt + 7'd1;
            r_num <= {r_num[62:0], 1'b0};
            r_rem <= w_sub[25] ? w_sh : w_sub;
        end else begin
            r_busy <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/bfe_back.sv =====
// ---------------------------------------------------------------------------
// bfe_back
// reduces each hash, reads and writes the bit store, runs the clear sweep
// ---------------------------------------------------------------------------
`default_nettype none
module bfe_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [24:0] i_filter_bits,
    input  wire logic [3:0]  i_hash_count,
    input  wire logic        i_job_vld,
    input  wire bfe_pkg::t_job i_job,
    output logic             o_job_rdy,
    output logic             o_res_vld,
    output logic [1:0]       o_res_kind,
    output logic             o_res_present,
    input  wire logic        i_res_rdy
);
    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_NEXT = 7'b0000100,
        S_MOD  = 7'b0001000,
        S_RD   = 7'b0010000,
        S_WR   = 7'b0100000,
        S_RES  = 7'b1000000
    } t_state;

    t_state r_st;
    logic [63:0] r_mem [bfe_pkg::ClrRows];
    logic [63:0] r_rd;
    logic [bfe_pkg::ClrCntW-1:0] r_row;
    bfe_pkg::t_job r_job;
    logic [bfe_pkg::HIdxW:0] r_hi;
    logic [bfe_pkg::HIdxW:0] w_k;
    logic [24:0] w_m;
    logic [24:0] r_idx;
    logic        r_all;
    logic        w_start;
    logic        w_done;
    logic [24:0] w_rem;
    logic [63:0] w_hash;

    assign w_m = (i_filter_bits == '0) ? 25'd1 :
                 (i_filter_bits > 25'(bfe_pkg::MaxBits)) ? 25'(bfe_pkg::MaxBits)
                                                          : i_filter_bits;
    assign w_k = (i_hash_count > 4'(bfe_pkg::MaxHashes)) ? 4'(bfe_pkg::MaxHashes)
                                                         : i_hash_count;
    assign w_hash = r_job.hashes[r_hi[bfe_pkg::HIdxW-1:0]*64 +: 64];
    assign w_start = (r_st == S_NEXT) && (r_hi < w_k);
    assign o_job_rdy = (r_st == S_IDLE);
    assign o_res_vld = (r_st == S_RES);
    assign o_res_kind = r_job.cmd;
    assign o_res_present = (r_job.cmd == bfe_pkg::CmdLookup) && r_all;

    bfe_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_hash),
        .i_den   (w_m),
        .o_done  (w_done),
        .o_rem   (w_rem)
    );

    // bit store, one 64-bit row per access
    always_ff @(posedge i_clk) begin
        if (r_st == S_CLR) begin
            r_mem[r_row] <= '0;
        end else if (r_st == S_WR && r_job.cmd == bfe_pkg::CmdInsert) begin
            r_mem[r_idx[23:6]] <= r_rd | (64'd1 << r_idx[5:0]);
        end
        r_rd <= r_mem[w_rem[23:6]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_CLR;
            r_row <= '0;
            r_hi  <= '0;
            r_all <= 1'b1;
        end else begin
            case (r_st)
                S_CLR: begin
                    r_row <= r_row + {{(bfe_pkg::ClrCntW-1){1'b0}}, 1'b1};
                    if (&r_row) begin
                        r_st <= (r_job.cmd == bfe_pkg::CmdClear && r_hi[0]) ? S_RES : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_job_vld) begin
                        r_job <= i_job;
                        r_all <= 1'b1;
                        if (i_job.cmd == bfe_pkg::CmdClear) begin
                            r_hi  <= {{bfe_pkg::HIdxW{1'b0}}, 1'b1};
                            r_row <= '0;
                            r_st  <= S_CLR;
                        end else begin
                            r_hi <= '0;
                            r_st <= S_NEXT;
                        end
                    end
                end
                S_NEXT: r_st <= w_start ? S_MOD : S_RES;
                S_MOD: begin
                    if (w_done) begin
                        r_idx <= w_rem;
                        r_st  <= S_RD;
                    end
                end
                S_RD: r_st <= S_WR;
                S_WR: begin
                    if (!r_rd[r_idx[5:0]]) r_all <= 1'b0;
                    r_hi <= r_hi + {{bfe_pkg::HIdxW{1'b0}}, 1'b1};
                    r_st <= S_NEXT;
                end
                S_RES: if (i_res_rdy) r_st <= S_IDLE;
                default: r_st <= S_CLR;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/bloom_filter_engine_top.sv =====
// key bytes are taken one a cycle; a finished key or a clear waits in a one-entry
// job slot, and input stalls only while that slot is full and the back end busy
// end of key: per hash a bit-serial remainder, a store read, then a store write and
// step, for up to eight hashes
// clear: one 64-bit store row a cycle over all 262144 rows; reset runs the same sweep
// reset is synchronous, active low
`default_nettype none
`include "bloom_filter_engine_top_defines.svh"
// ---------------------------------------------------------------------------
// bloom_filter_engine_top
// bloom filter with up to eight seeded hashes over streamed keys
// ---------------------------------------------------------------------------
module bloom_filter_engine_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_command,
    input  wire logic [7:0]  i_key_byte,
    input  wire logic        i_last_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_done_kind,
    output logic             o_present,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [24:0] i_cfg_data
);
    logic [24:0] r_filter_bits;
    logic [3:0]  r_hash_count;
    logic        w_job_vld;
    logic        w_job_rdy;
    bfe_pkg::t_job w_job;
    logic        w_res_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_bits <= bfe_pkg::FilterBitsRst;
            r_hash_count  <= bfe_pkg::HashCountRst;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bfe_pkg::RegFilterBits: r_filter_bits <= i_cfg_data;
                bfe_pkg::RegHashCount:  r_hash_count  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    bfe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_command   (i_command),
        .i_key_byte  (i_key_byte),
        .i_last_byte (i_last_byte),
        .o_job_vld   (w_job_vld),
        .o_job       (w_job),
        .i_job_rdy   (w_job_rdy)
    );

    bfe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_filter_bits (r_filter_bits),
        .i_hash_count  (r_hash_count),
        .i_job_vld     (w_job_vld),
        .i_job         (w_job),
        .o_job_rdy     (w_job_rdy),
        .o_res_vld     (w_res_vld),
        .o_res_kind    (o_done_kind),
        .o_res_present (o_present),
        .i_res_rdy     (pop)
    );

    assign empty = !w_res_vld;

    `BFE_ASSERT(a_full_when_slot_stuck, i_clk, i_rst_n, (w_job_vld && !w_job_rdy) |-> full)
    `BFE_ASSERT(a_present_only_lookup, i_clk, i_rst_n, (!empty && o_present) |-> !o_done_kind[1])
    `BFE_ASSERT(a_result_held, i_clk, i_rst_n, (!empty && !pop) |=> !empty)
    `BFE_ASSERT_NR(a_reset_empty, i_clk, !$past(i_rst_n) |-> empty)
endmodule
`default_nettype wire

// ===== dv/bloom_filter_engine_top_tb.sv =====
// ---------------------------------------------------------------------------
// bloom_filter_engine_top_tb
// streams keys, lookups, clears and junk commands through the engine under
// several filter sizes and hash counts, and checks every result against a
// bit-accurate prediction of the filter kept in the testbench
// ---------------------------------------------------------------------------
`default_nettype none
module bloom_filter_engine_top_tb;
    localparam int         SettleCycles = 700;
    localparam longint     CycleLimit = 10000000;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] kb;
        logic       lb;
    } t_key_item;

    typedef struct {
        logic [1:0] kind;
        logic       present;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_command;
    logic [7:0]  i_key_byte;
    logic        i_last_byte;
    logic        empty;
    logic        pop;
    logic [1:0]  o_done_kind;
    logic        o_present;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [24:0] i_cfg_data;

    t_key_item   item_q[$];
    t_outcome    outcome_q[$];
    logic [63:0] run_hash[bfe_pkg::MaxHashes];
    bit          filter_set[int unsigned];
    logic [24:0] cur_bits;
    logic [3:0]  cur_hashes;
    int          errors = 0;
    int          send_gap;
    int          recv_gap;
    bit          burst_mode;
    longint      cycles = 0;
    logic [7:0]  key_pool[16][4];
    int          key_len[16];

    bloom_filter_engine_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_command(i_command), .i_key_byte(i_key_byte), .i_last_byte(i_last_byte),
        .empty(empty), .pop(pop), .o_done_kind(o_done_kind), .o_present(o_present),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void reseed();
        for (int i = 0; i < bfe_pkg::MaxHashes; i++) run_hash[i] = 64'(i + 1);
    endfunction

    // advance the filter by one accepted transfer and queue what it should produce
    function automatic void filter_step(t_key_item it);
        logic [63:0] sext;
        logic [63:0] modulus;
        int          k;
        bit          all_set;
        int unsigned pos;
        t_outcome    res;
        if (it.cmd == bfe_pkg::CmdIgnore) return;
        if (it.cmd == bfe_pkg::CmdClear) begin
            filter_set.delete();
            reseed();
            res.kind = bfe_pkg::CmdClear;
            res.present = 1'b0;
            outcome_q = {outcome_q, res};
            return;
        end
        sext = {{56{it.kb[7]}}, it.kb};
        for (int i = 0; i < bfe_pkg::MaxHashes; i++)
            run_hash[i] = run_hash[i] * 64'd131 + sext;
        if (!it.lb) return;
        modulus = (cur_bits == 0) ? 64'd1 :
                  (cur_bits > bfe_pkg::MaxBits) ? 64'(bfe_pkg::MaxBits) : 64'(cur_bits);
        k = (cur_hashes > bfe_pkg::MaxHashes) ? bfe_pkg::MaxHashes : int'(cur_hashes);
        all_set = 1'b1;
        for (int i = 0; i < k; i++) begin
            pos = 32'(run_hash[i] % modulus);
            if (it.cmd == bfe_pkg::CmdInsert) filter_set[pos] = 1'b1;
            else if (!filter_set.exists(pos)) all_set = 1'b0;
        end
        reseed();
        res.kind = it.cmd;
        res.present = (it.cmd == bfe_pkg::CmdLookup) && all_set;
        outcome_q = {outcome_q, res};
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_key_item it;
        if (!i_rst_n) begin
            push <= 1'b0;
            send_gap <= 0;
        end else if (push && !full) begin
            it.cmd = i_command;
            it.kb = i_key_byte;
            it.lb = i_last_byte;
            filter_step(it);
            push <= 1'b0;
            send_gap <= burst_mode ? 0 : $urandom_range(0, 15);
        end else if (!push) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (item_q.size() > 0) begin
                it = item_q.pop_front();
                i_command <= it.cmd;
                i_key_byte <= it.kb;
                i_last_byte <= it.lb;
                push <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            pop <= 1'b0;
            recv_gap <= 0;
        end else if (pop && !empty) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: unexpected transfer kind=%0d present=%0d",
                         $time, o_done_kind, o_present);
                errors++;
            end else begin
                want = outcome_q.pop_front();
                if (o_done_kind !== want.kind) begin
                    $display("%0t: done_kind expected %0d actual %0d",
                             $time, want.kind, o_done_kind);
                    errors++;
                end
                if (o_present !== want.present) begin
                    $display("%0t: present expected %0d actual %0d",
                             $time, want.present, o_present);
                    errors++;
                end
            end
            pop <= 1'b0;
            recv_gap <= burst_mode ? 0 : $urandom_range(0, 15);
        end else if (!pop) begin
            if (recv_gap > 0) recv_gap <= recv_gap - 1;
            else pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic add(logic [1:0] cmd, logic [7:0] kb, logic lb);
        t_key_item it;
        it.cmd = cmd;
        it.kb = kb;
        it.lb = lb;
        item_q = {item_q, it};
    endtask

    // whole key from the pool; earlier bytes sometimes carry the other command
    task automatic add_key(int sel, logic [1:0] cmd);
        for (int j = 0; j < key_len[sel]; j++) begin
            if (j == key_len[sel] - 1) add(cmd, key_pool[sel][j], 1'b1);
            else add($urandom_range(0, 3) == 0 ? ~cmd & 2'b01 : cmd,
                     key_pool[sel][j], 1'b0);
        end
    endtask

    task automatic new_pool();
        for (int i = 0; i < 16; i++) begin
            key_len[i] = $urandom_range(1, 4);
            for (int j = 0; j < 4; j++) key_pool[i][j] = 8'($urandom);
        end
    endtask

    task automatic wait_idle();
        while (item_q.size() > 0 || push || outcome_q.size() > 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [24:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bfe_pkg::RegFilterBits) cur_bits = val;
        else cur_hashes = val[3:0];
    endtask

    task automatic random_phase(int n, bit with_clear);
        int r;
        int made;
        int iter;
        int base;
        made = 0;
        iter = 0;
        base = item_q.size();
        new_pool();
        while (made < n) begin
            if (iter % 16 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 85) begin
                add_key($urandom_range(0, 15),
                        $urandom_range(0, 1) ? bfe_pkg::CmdLookup : bfe_pkg::CmdInsert);
            end else if (r < 92) begin
                add(bfe_pkg::CmdIgnore, 8'($urandom), 1'($urandom));
            end else begin
                // broken key: a partial key that runs straight into a fresh one
                add($urandom_range(0, 1) ? bfe_pkg::CmdLookup : bfe_pkg::CmdInsert,
                    8'($urandom), 1'b0);
                add_key($urandom_range(0, 15),
                        $urandom_range(0, 1) ? bfe_pkg::CmdLookup : bfe_pkg::CmdInsert);
            end
            iter++;
            made = item_q.size() - base;
        end
        if (with_clear) begin
            add(bfe_pkg::CmdInsert, 8'h55, 1'b0);
            add(bfe_pkg::CmdClear, 8'($urandom), 1'($urandom));
            add_key(0, bfe_pkg::CmdLookup);
        end
        burst_mode = 1'b0;
        wait_idle();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_command = bfe_pkg::CmdInsert;
        i_key_byte = 8'h00;
        i_last_byte = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = bfe_pkg::RegFilterBits;
        i_cfg_data = '0;
        burst_mode = 1'b0;
        cur_bits = bfe_pkg::FilterBitsRst;
        cur_hashes = bfe_pkg::HashCountRst;
        reseed();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: byte extremes, both key kinds, junk, clear mid-key
        add(bfe_pkg::CmdInsert, 8'h00, 1'b0);
        add(bfe_pkg::CmdInsert, 8'hFF, 1'b0);
        add(bfe_pkg::CmdInsert, 8'h80, 1'b0);
        add(bfe_pkg::CmdInsert, 8'h7F, 1'b1);
        add(bfe_pkg::CmdLookup, 8'h00, 1'b0);
        add(bfe_pkg::CmdLookup, 8'hFF, 1'b0);
        add(bfe_pkg::CmdLookup, 8'h80, 1'b0);
        add(bfe_pkg::CmdLookup, 8'h7F, 1'b1);
        add(bfe_pkg::CmdLookup, 8'h01, 1'b1);
        add(bfe_pkg::CmdIgnore, 8'hA5, 1'b1);
        add(bfe_pkg::CmdInsert, 8'h7F, 1'b0);
        add(bfe_pkg::CmdLookup, 8'h80, 1'b1);
        add(bfe_pkg::CmdInsert, 8'h33, 1'b0);
        add(bfe_pkg::CmdClear, 8'hFF, 1'b1);
        add(bfe_pkg::CmdLookup, 8'h00, 1'b0);
        add(bfe_pkg::CmdLookup, 8'hFF, 1'b0);
        add(bfe_pkg::CmdLookup, 8'h80, 1'b0);
        add(bfe_pkg::CmdLookup, 8'h7F, 1'b1);
        wait_idle();

        random_phase(120, 1'b0);
        write_reg(bfe_pkg::RegFilterBits, 25'd1);
        write_reg(bfe_pkg::RegHashCount, 25'd1);
        random_phase(100, 1'b0);
        write_reg(bfe_pkg::RegFilterBits, 25'd0);
        write_reg(bfe_pkg::RegHashCount, 25'd8);
        random_phase(100, 1'b0);
        write_reg(bfe_pkg::RegFilterBits, 25'd16777216);
        random_phase(110, 1'b1);
        write_reg(bfe_pkg::RegFilterBits, 25'h1FFFFFF);
        write_reg(bfe_pkg::RegHashCount, 25'd15);
        random_phase(110, 1'b0);
        // zero hashes: inserts do nothing, lookups always hit
        write_reg(bfe_pkg::RegHashCount, 25'd0);
        random_phase(80, 1'b0);
        write_reg(bfe_pkg::RegFilterBits, 25'd100);
        write_reg(bfe_pkg::RegHashCount, 25'd3);
        random_phase(160, 1'b0);
        write_reg(bfe_pkg::RegFilterBits, 25'd64);
        write_reg(bfe_pkg::RegHashCount, 25'd2);
        random_phase(160, 1'b0);

        if (errors == 0 && outcome_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
